[rtl/core/nkfc_pkg.sv]
// Package for the nearest-k filtered cells unit.
// Holds sizes, the kept-entry and queue-entry types; no dependencies.
package nkfc_pkg;

    localparam int KEEP_MAX    = 16;
    localparam int GRID_SIDE   = 256;
    localparam int OUT_MAX     = 16;
    localparam int N_LIM       = (KEEP_MAX < OUT_MAX) ? KEEP_MAX : OUT_MAX;
    localparam int KC_W        = $clog2(KEEP_MAX + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int COORD_W = 8;
    localparam int DIST_W  = 20;
    localparam int INFL_W  = 16;
    localparam int SIDE_W  = 8;
    localparam int WANT_W  = 5;
    localparam int WORLD_W = 16;
    localparam int CIDX_W  = 4;

    localparam logic [CIDX_W-1:0] REG_CELL_SIDE    = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] REG_COUNT_WANTED = CIDX_W'(1);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DIST_W-1:0]  distance;
    } entry_t;

    typedef struct packed {
        entry_t ent;
        logic   cand;
        logic   last;
    } q_item_t;

endpackage

[rtl/core/nkfc_front.sv]
// Front end: accepts cells, marks candidates, and queues them for the back end.
// Depends on nkfc_pkg.
module nkfc_front import nkfc_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [COORD_W-1:0]        s_cell_x,
    input  logic [COORD_W-1:0]        s_cell_y,
    input  logic signed [INFL_W-1:0]  s_influence,
    input  logic [DIST_W-1:0]         s_distance,
    input  logic                      s_last_cell,
    output logic                      q_valid,
    input  logic                      q_ready,
    output q_item_t                   q_item
);

    q_item_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    q_item_t            in_item;
    logic               push;
    logic               pop;

    always_comb begin
        in_item.ent.x        = s_cell_x;
        in_item.ent.y        = s_cell_y;
        in_item.ent.distance = s_distance;
        in_item.cand         = (s_influence == '0);
        in_item.last         = s_last_cell;
    end

    assign s_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[rtl/core/nkfc_back.sv]
// Back end: sorted insertion list of kept cells, result drain and output register.
// Depends on nkfc_pkg.
module nkfc_back import nkfc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [SIDE_W-1:0]     cell_side,
    input  logic [WANT_W-1:0]     count_wanted,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  q_item_t               q_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [WORLD_W-1:0]    m_world_x,
    output logic [WORLD_W-1:0]    m_world_y,
    output logic                  m_found,
    output logic                  m_last_result
);

    typedef enum logic {ST_RUN, ST_DRAIN} state_t;

    state_t              state_reg;
    entry_t              list_reg [KEEP_MAX];
    entry_t              ins [KEEP_MAX];
    logic [KEEP_MAX-1:0] le;
    logic [KC_W-1:0]     kept_reg;
    logic [KC_W-1:0]     kept_ins;
    logic [WANT_W-1:0]   remain_reg;
    logic [WANT_W-1:0]   n_out;
    logic                m_valid_reg;
    logic [WORLD_W-1:0]  wx_reg;
    logic [WORLD_W-1:0]  wy_reg;
    logic                found_reg;
    logic                last_reg;
    logic                pop;
    logic                out_free;
    logic                have;

    assign q_ready  = (state_reg == ST_RUN);
    assign pop      = q_valid && q_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign have     = (kept_reg != '0);

    always_comb begin
        for (int i = 0; i < KEEP_MAX; i++) begin
            le[i] = (KC_W'(i) < kept_reg) && (list_reg[i].distance <= q_item.ent.distance);
        end
        for (int i = 0; i < KEEP_MAX; i++) begin
            if (le[i]) begin
                ins[i] = list_reg[i];
            end else if (i == 0) begin
                ins[i] = q_item.ent;
            end else if (le[(i > 0) ? i - 1 : 0]) begin
                ins[i] = q_item.ent;
            end else begin
                ins[i] = list_reg[(i > 0) ? i - 1 : 0];
            end
        end
        kept_ins = (kept_reg < KC_W'(KEEP_MAX)) ? kept_reg + 1'b1 : kept_reg;
        n_out    = (count_wanted > WANT_W'(N_LIM)) ? WANT_W'(N_LIM) : count_wanted;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            kept_reg    <= '0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_RUN: begin
                    if (m_valid_reg && m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                    if (pop) begin
                        if (q_item.cand) begin
                            for (int i = 0; i < KEEP_MAX; i++) begin
                                list_reg[i] <= ins[i];
                            end
                        end
                        if (q_item.last && n_out == '0) begin
                            kept_reg <= '0;
                        end else if (q_item.cand) begin
                            kept_reg <= kept_ins;
                        end
                        if (q_item.last && n_out != '0) begin
                            remain_reg <= n_out;
                            state_reg  <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        wx_reg      <= have ? WORLD_W'(list_reg[0].x) * WORLD_W'(cell_side) : '0;
                        wy_reg      <= have ? WORLD_W'(list_reg[0].y) * WORLD_W'(cell_side) : '0;
                        found_reg   <= have;
                        last_reg    <= (remain_reg == WANT_W'(1));
                        for (int i = 0; i < KEEP_MAX - 1; i++) begin
                            list_reg[i] <= list_reg[i + 1];
                        end
                        remain_reg <= remain_reg - 1'b1;
                        if (remain_reg == WANT_W'(1)) begin
                            kept_reg  <= '0;
                            state_reg <= ST_RUN;
                        end else begin
                            kept_reg <= have ? kept_reg - 1'b1 : '0;
                        end
                    end
                end
                default: state_reg <= ST_RUN;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_world_x     = wx_reg;
    assign m_world_y     = wy_reg;
    assign m_found       = found_reg;
    assign m_last_result = last_reg;

endmodule

[rtl/core/nearest_k_filtered_cells_unit.sv]
// Top level of the nearest-k filtered cells unit: config registers, front and back.
// Depends on nkfc_pkg, nkfc_front and nkfc_back.
//
// Cells with zero influence are kept, sorted by distance, in a list of KEEP_MAX
// entries; equal distances keep arrival order. The front takes one cell per cycle
// into a two-entry queue while it is not full, and the back inserts one queued cell
// per cycle. The transfer with last_cell set triggers a drain of count_wanted results
// (saturated to KEEP_MAX), one per cycle while the output is taken, nearest first,
// with found = 0 for missing entries; insertion pauses during the drain. Write
// config only while idle.
module nearest_k_filtered_cells_unit import nkfc_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CIDX_W-1:0]         cfg_index,
    input  logic [SIDE_W-1:0]         cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [COORD_W-1:0]        s_cell_x,
    input  logic [COORD_W-1:0]        s_cell_y,
    input  logic signed [INFL_W-1:0]  s_influence,
    input  logic [DIST_W-1:0]         s_distance,
    input  logic                      s_last_cell,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [WORLD_W-1:0]        m_world_x,
    output logic [WORLD_W-1:0]        m_world_y,
    output logic                      m_found,
    output logic                      m_last_result
);

    logic [SIDE_W-1:0] cell_side_reg;
    logic [WANT_W-1:0] count_wanted_reg;
    logic              q_valid;
    logic              q_ready;
    q_item_t           q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_side_reg    <= SIDE_W'(32);
            count_wanted_reg <= WANT_W'(4);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_CELL_SIDE:    cell_side_reg    <= cfg_data;
                REG_COUNT_WANTED: count_wanted_reg <= cfg_data[WANT_W-1:0];
                default:          ;
            endcase
        end
    end

    nkfc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cell_x    (s_cell_x),
        .s_cell_y    (s_cell_y),
        .s_influence (s_influence),
        .s_distance  (s_distance),
        .s_last_cell (s_last_cell),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item)
    );

    nkfc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cell_side     (cell_side_reg),
        .count_wanted  (count_wanted_reg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_world_x     (m_world_x),
        .m_world_y     (m_world_y),
        .m_found       (m_found),
        .m_last_result (m_last_result)
    );

endmodule

[rtl/core/nkfc_checker.sv]
// Port-level checker for the nearest-k filtered cells unit, bound to the top level.
// Depends on nkfc_pkg and nearest_k_filtered_cells_unit.
module nkfc_checker import nkfc_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [WORLD_W-1:0]        m_world_x,
    input logic [WORLD_W-1:0]        m_world_y,
    input logic                      m_found,
    input logic                      m_last_result
);

    logic missing_reg;

    // once a result is missing, the rest of that run is missing too
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            missing_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            missing_reg <= !m_found && !m_last_result;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_world_x) && $stable(m_world_y)
            && $stable(m_found) && $stable(m_last_result))
        else $error("result changed while stalled");

    a_missing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_world_x == '0 && m_world_y == '0)
        else $error("missing result with nonzero coordinates");

    a_missing_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && missing_reg |-> !m_found)
        else $error("found result after a missing one");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("config write not taken");

endmodule

bind nearest_k_filtered_cells_unit nkfc_checker u_nkfc_checker (.*);
